// ----- sv/nklc_pkg.sv -----
// ----------------------------------------------------------------------------
// nklc_pkg - shared constants and types for the name-keyed LRU cache
// Sizes, request and status codes, sequencer states, entry metadata.
// ----------------------------------------------------------------------------
package nklc_pkg;

  localparam int ENTRIES    = 64;
  localparam int NAME_BYTES = 256;
  localparam int BUCKETS    = 64;   // power of two: bucket is the low hash bits

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int NB_W  = $clog2(NAME_BYTES);
  localparam int LEN_W = $clog2(NAME_BYTES + 2);
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int CAP_W = 7;
  localparam int NS_W  = IDX_W + NB_W;

  localparam int HASH_SEED  = 5381;
  localparam int HASH_SHIFT = 5;

  localparam logic [15:0]      TYPE_A    = 16'd1;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    REQ_QUERY  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_EVICT  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_HIT       = 4'd0,
    ST_MISS      = 4'd1,
    ST_SKIPPED   = 4'd2,
    ST_UPDATED   = 4'd3,
    ST_ADDED     = 4'd4,
    ST_ADD_EVICT = 4'd5,
    ST_EVICTED   = 4'd6,
    ST_NO_EVICT  = 4'd7,
    ST_TOO_LONG  = 4'd8
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE,
    S_F_RD, S_F_CHK, S_N_RD, S_N_CHK,
    S_H_RD, S_H_WT, S_MR_RD, S_MR_WR, S_MR_FIN,
    S_E_RD, S_E_CHK,
    S_A_SLOT, S_AR_RD, S_AR_WR, S_C_RD, S_C_WR, S_A_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [BKT_W-1:0] bkt;
    logic [NB_W-1:0]  len_m1;
    logic [15:0]      rtype;
  } meta_t;

endpackage

// ----- sv/nklc_ram.sv -----
// ----------------------------------------------------------------------------
// nklc_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nklc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/name_keyed_lru_cache.sv -----
// ----------------------------------------------------------------------------
// name_keyed_lru_cache - name to IPv4 cache with LRU replacement
// Name bytes stream in one word per cycle while idle; on the last byte a sequencer
// walks the entry RAMs with one shared compare unit to run the request.
// ----------------------------------------------------------------------------
// Steps: a last byte word is decided, then a find walk compares metadata and name
//   bytes; a hit moves its entry to the front, a new insert evicts when full, finds
//   a free slot, ages the ranks and copies the name; an evict walks for the oldest.
// Throughput: one byte word per cycle while the sequencer is idle; one request at
//   a time, input stalled until its result word (if any) enters the output register.
// Reset: entries invalid, count zero, capacity 64, name hash at its seed.
module name_keyed_lru_cache
  import nklc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: capacity
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i,
  // request words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         name_byte_i,
  input  logic               name_last_i,
  input  logic [15:0]        record_type_i,
  input  logic [31:0]        address_in_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         status_o,
  output logic [31:0]        address_out_o,
  output logic [CNT_W-1:0]   entry_count_o
);

  state_e state_q, state_d;

  logic [CAP_W-1:0]   cap_q;
  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   held_q;
  logic [LEN_W-1:0]   len_q;
  logic [BKT_W-1:0]   hash_q;

  // latched request
  req_e             req_q;
  logic [15:0]      rtype_q;
  logic [31:0]      addr_q;
  logic [NB_W-1:0]  lm1_q;
  logic [BKT_W-1:0] bkt_q;
  logic             too_long_q;

  // walk state
  logic [IDX_W-1:0] idx_q, hit_q, slot_q, rh_q;
  logic [NB_W-1:0]  bi_q;
  logic             evicted_q;
  status_e          res_status_q;
  logic [31:0]      res_addr_q;

  logic             out_valid_q;
  logic [3:0]       status_q;
  logic [31:0]      addr_out_q;
  logic [CNT_W-1:0] count_q;

  // RAM ports
  meta_t            meta_rd, meta_wd;
  logic             meta_we;
  logic [31:0]      ea_rd;
  logic             ea_we;
  logic [IDX_W-1:0] ea_waddr;
  logic [IDX_W-1:0] rank_rd, rank_wd, rank_waddr, rank_raddr;
  logic             rank_we;
  logic [7:0]       nm_rd, inc_rd;
  logic             nm_we, inc_we;

  // handshake and byte folding
  logic             in_acc, out_free;
  logic [LEN_W-1:0] len_nx;
  logic [BKT_W-1:0] hash_nx;
  logic [CAP_W-1:0] cap_eff;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign len_nx  = (len_q <= LEN_W'(NAME_BYTES)) ? LEN_W'(len_q + LEN_W'(1)) : len_q;
  assign hash_nx = BKT_W'((hash_q << HASH_SHIFT) + hash_q + BKT_W'(name_byte_i));

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_q > CAP_W'(ENTRIES)) begin
      cap_eff = CAP_W'(ENTRIES);
    end else begin
      cap_eff = cap_q;
    end
  end

  // shared compare unit
  logic vld_idx, last_idx, f_match, n_eq, n_last, e_match, need_evict;
  assign vld_idx    = valid_q[idx_q];
  assign last_idx   = (idx_q == IDX_W'(ENTRIES - 1));
  assign f_match    = vld_idx && (meta_rd.bkt == bkt_q) && (meta_rd.rtype == rtype_q)
                      && (meta_rd.len_m1 == lm1_q);
  assign n_eq       = (nm_rd == inc_rd);
  assign n_last     = (bi_q == lm1_q);
  assign e_match    = vld_idx && ({1'b0, rank_rd} == CNT_W'(held_q - CNT_W'(1)));
  assign need_evict = (held_q >= CNT_W'(cap_eff));

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc && name_last_i) state_d = S_DECIDE;
      S_DECIDE: begin
        case (req_q)
          REQ_RSVD:   state_d = S_IDLE;
          REQ_EVICT:  state_d = S_E_RD;
          REQ_INSERT: state_d = (rtype_q != TYPE_A || too_long_q) ? S_DONE : S_F_RD;
          default:    state_d = too_long_q ? S_DONE : S_F_RD;
        endcase
      end
      S_F_RD:   state_d = S_F_CHK;
      S_F_CHK: begin
        if (f_match) begin
          state_d = S_N_RD;
        end else if (!last_idx) begin
          state_d = S_F_RD;
        end else if (req_q == REQ_QUERY) begin
          state_d = S_DONE;
        end else begin
          state_d = need_evict ? S_E_RD : S_A_SLOT;
        end
      end
      S_N_RD:   state_d = S_N_CHK;
      S_N_CHK: begin
        if (n_eq && n_last) begin
          state_d = S_H_RD;
        end else if (n_eq) begin
          state_d = S_N_RD;
        end else if (!last_idx) begin
          state_d = S_F_RD;
        end else if (req_q == REQ_QUERY) begin
          state_d = S_DONE;
        end else begin
          state_d = need_evict ? S_E_RD : S_A_SLOT;
        end
      end
      S_H_RD:   state_d = S_H_WT;
      S_H_WT:   state_d = S_MR_RD;
      S_MR_RD:  state_d = S_MR_WR;
      S_MR_WR:  state_d = last_idx ? S_MR_FIN : S_MR_RD;
      S_MR_FIN: state_d = S_DONE;
      S_E_RD:   state_d = S_E_CHK;
      S_E_CHK: begin
        if (e_match || last_idx) begin
          state_d = (req_q == REQ_EVICT) ? S_DONE : S_A_SLOT;
        end else begin
          state_d = S_E_RD;
        end
      end
      S_A_SLOT: begin
        if (!vld_idx) begin
          state_d = S_AR_RD;
        end else if (last_idx) begin
          state_d = S_DONE;
        end
      end
      S_AR_RD:  state_d = S_AR_WR;
      S_AR_WR:  state_d = last_idx ? S_C_RD : S_AR_RD;
      S_C_RD:   state_d = S_C_WR;
      S_C_WR:   state_d = n_last ? S_A_FIN : S_C_RD;
      S_A_FIN:  state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------- RAM controls ----------------
  always_comb begin
    meta_we    = (state_q == S_A_FIN);
    meta_wd    = '{bkt: bkt_q, len_m1: lm1_q, rtype: rtype_q};
    ea_we      = (state_q == S_A_FIN) || (state_q == S_H_RD && req_q == REQ_INSERT);
    ea_waddr   = (state_q == S_A_FIN) ? slot_q : hit_q;
    rank_raddr = (state_q == S_H_RD) ? hit_q : idx_q;
    rank_we    = 1'b0;
    rank_waddr = idx_q;
    rank_wd    = IDX_W'(rank_rd + IDX_W'(1));
    case (state_q)
      S_MR_WR:  rank_we = vld_idx && (idx_q != hit_q) && (rank_rd < rh_q);
      S_AR_WR:  rank_we = vld_idx;
      S_MR_FIN: begin
        rank_we    = 1'b1;
        rank_waddr = hit_q;
        rank_wd    = '0;
      end
      S_A_FIN: begin
        rank_we    = 1'b1;
        rank_waddr = slot_q;
        rank_wd    = '0;
      end
      default: rank_we = 1'b0;
    endcase
    nm_we  = (state_q == S_C_WR);
    inc_we = in_acc && (len_q < LEN_W'(NAME_BYTES));
  end

  nklc_ram #(.WIDTH($bits(meta_t)), .DEPTH(ENTRIES)) u_meta (
    .clk_i, .we_i(meta_we), .waddr_i(slot_q), .wdata_i(meta_wd),
    .raddr_i(idx_q), .rdata_o(meta_rd)
  );

  nklc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_addr (
    .clk_i, .we_i(ea_we), .waddr_i(ea_waddr), .wdata_i(addr_q),
    .raddr_i(hit_q), .rdata_o(ea_rd)
  );

  nklc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank (
    .clk_i, .we_i(rank_we), .waddr_i(rank_waddr), .wdata_i(rank_wd),
    .raddr_i(rank_raddr), .rdata_o(rank_rd)
  );

  // stored names: one row of NAME_BYTES per entry
  nklc_ram #(.WIDTH(8), .DEPTH(ENTRIES * NAME_BYTES)) u_names (
    .clk_i, .we_i(nm_we), .waddr_i(NS_W'({slot_q, bi_q})), .wdata_i(inc_rd),
    .raddr_i(NS_W'({idx_q, bi_q})), .rdata_o(nm_rd)
  );

  // name being received
  nklc_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_incoming (
    .clk_i, .we_i(inc_we), .waddr_i(len_q[NB_W-1:0]), .wdata_i(name_byte_i),
    .raddr_i(bi_q), .rdata_o(inc_rd)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cap_q        <= CAP_RESET;
      valid_q      <= '0;
      held_q       <= '0;
      len_q        <= '0;
      hash_q       <= BKT_W'(HASH_SEED);
      out_valid_q  <= 1'b0;
      evicted_q    <= 1'b0;
      idx_q        <= '0;
      hit_q        <= '0;
      slot_q       <= '0;
      rh_q         <= '0;
      bi_q         <= '0;
      res_status_q <= ST_MISS;
      res_addr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        if (name_last_i) begin
          len_q  <= '0;
          hash_q <= BKT_W'(HASH_SEED);
        end else begin
          len_q  <= len_nx;
          hash_q <= hash_nx;
        end
      end

      case (state_q)
        S_DECIDE: begin
          idx_q      <= '0;
          evicted_q  <= 1'b0;
          res_addr_q <= '0;
          if (req_q == REQ_INSERT && rtype_q != TYPE_A) begin
            res_status_q <= ST_SKIPPED;
          end else if (too_long_q) begin
            res_status_q <= ST_TOO_LONG;
          end
        end
        S_F_CHK: begin
          bi_q <= '0;
          if (!f_match) begin
            idx_q <= last_idx ? '0 : IDX_W'(idx_q + IDX_W'(1));
            if (last_idx) res_status_q <= ST_MISS;
          end
        end
        S_N_CHK: begin
          if (n_eq && n_last) begin
            hit_q <= idx_q;
          end else if (n_eq) begin
            bi_q <= NB_W'(bi_q + NB_W'(1));
          end else begin
            idx_q <= last_idx ? '0 : IDX_W'(idx_q + IDX_W'(1));
            if (last_idx) res_status_q <= ST_MISS;
          end
        end
        S_H_WT: begin
          rh_q  <= rank_rd;
          idx_q <= '0;
          if (req_q == REQ_QUERY) res_addr_q <= ea_rd;
        end
        S_MR_WR:  idx_q <= IDX_W'(idx_q + IDX_W'(1));
        S_MR_FIN: res_status_q <= (req_q == REQ_QUERY) ? ST_HIT : ST_UPDATED;
        S_E_CHK: begin
          if (e_match) begin
            valid_q[idx_q] <= 1'b0;
            held_q         <= CNT_W'(held_q - CNT_W'(1));
            evicted_q      <= 1'b1;
          end
          if (e_match || last_idx) begin
            idx_q        <= '0;
            res_status_q <= e_match ? ST_EVICTED : ST_NO_EVICT;
          end else begin
            idx_q <= IDX_W'(idx_q + IDX_W'(1));
          end
        end
        S_A_SLOT: begin
          res_status_q <= evicted_q ? ST_ADD_EVICT : ST_ADDED;
          if (!vld_idx) begin
            slot_q <= idx_q;
            idx_q  <= '0;
          end else begin
            idx_q <= IDX_W'(idx_q + IDX_W'(1));
          end
        end
        S_AR_WR: begin
          idx_q <= IDX_W'(idx_q + IDX_W'(1));
          bi_q  <= '0;
        end
        S_C_WR:   bi_q <= NB_W'(bi_q + NB_W'(1));
        S_A_FIN: begin
          valid_q[slot_q] <= 1'b1;
          held_q          <= CNT_W'(held_q + CNT_W'(1));
        end
        default: ;
      endcase
    end
  end

  // request latch and result word payload
  always_ff @(posedge clk_i) begin
    if (in_acc && name_last_i) begin
      req_q      <= req_e'(req_type_i);
      rtype_q    <= record_type_i;
      addr_q     <= address_in_i;
      lm1_q      <= len_q[NB_W-1:0];
      bkt_q      <= hash_nx;
      too_long_q <= (len_nx > LEN_W'(NAME_BYTES));
    end
    if (state_q == S_DONE && out_free) begin
      status_q   <= res_status_q;
      addr_out_q <= res_addr_q;
      count_q    <= held_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign address_out_o = addr_out_q;
  assign entry_count_o = count_q;

  // ---------------- assertions ----------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_count_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == CNT_W'($countones(valid_q)))
    else $error("entry count out of step with valid bits");

  a_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_FIN) |-> !valid_q[slot_q])
    else $error("adding into an occupied slot");

endmodule

// ----- tb/tb_name_keyed_lru_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_name_keyed_lru_cache - self-checking bench for the name-keyed LRU cache
// Streams names byte by byte with random request content. A scoreboard
// holds its own copy of the cache and checks every result word in order.
// Capacity is changed between drained phases, extremes included.
// ----------------------------------------------------------------------------
module tb_name_keyed_lru_cache
  import nklc_pkg::*;
();

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_WAIT  = 2000;   // extra wait once no answers are owed
  localparam int ITEM_TARGET = 1400;

  typedef struct {
    logic [3:0]       status;
    logic [31:0]      addr;
    logic [CNT_W-1:0] count;
  } cache_answer_t;

  // --------------------------------------------------------------------------
  // Scoreboard: private cache copy plus the queue of answers still owed
  // --------------------------------------------------------------------------
  class lru_scoreboard;
    logic [CAP_W-1:0] capacity;
    logic [7:0]  names[ENTRIES][NAME_BYTES];
    int          lens[ENTRIES];
    logic [15:0] rtypes[ENTRIES];
    logic [31:0] addrs[ENTRIES];
    bit          valid[ENTRIES];
    int          rank[ENTRIES];
    logic [BKT_W-1:0] bkts[ENTRIES];
    int          held;
    logic [7:0]  cur_name[NAME_BYTES];
    int          cur_len;
    logic [31:0] hash;
    cache_answer_t owed[$];
    int          mismatches;

    function new();
      capacity = CAP_RESET;
      foreach (valid[e]) valid[e] = 0;
      held = 0;
      cur_len = 0;
      hash = HASH_SEED;
      mismatches = 0;
    endfunction

    function int lookup(int len, logic [BKT_W-1:0] b, logic [15:0] t);
      bit same;
      for (int e = 0; e < ENTRIES; e++) begin
        if (!valid[e] || bkts[e] != b || rtypes[e] != t || lens[e] != len) continue;
        same = 1;
        for (int i = 0; i < len; i++)
          if (names[e][i] != cur_name[i]) same = 0;
        if (same) return e;
      end
      return -1;
    endfunction

    function void touch(int hit);
      for (int e = 0; e < ENTRIES; e++)
        if (valid[e] && e != hit && rank[e] < rank[hit]) rank[e]++;
      rank[hit] = 0;
    endfunction

    function bit drop_oldest();
      if (held == 0) return 0;
      for (int e = 0; e < ENTRIES; e++)
        if (valid[e] && rank[e] == held - 1) begin
          valid[e] = 0;
          held--;
          return 1;
        end
      return 0;
    endfunction

    function void add(int len, logic [BKT_W-1:0] b, logic [15:0] t, logic [31:0] a);
      int slot;
      slot = -1;
      for (int e = 0; e < ENTRIES && slot < 0; e++)
        if (!valid[e]) slot = e;
      if (slot < 0) return;
      for (int e = 0; e < ENTRIES; e++)
        if (valid[e]) rank[e]++;
      for (int i = 0; i < len; i++) names[slot][i] = cur_name[i];
      lens[slot] = len;
      rtypes[slot] = t;
      addrs[slot] = a;
      bkts[slot] = b;
      rank[slot] = 0;
      valid[slot] = 1;
      held++;
    endfunction

    // called for every accepted request word
    function void note_word(logic [1:0] req, logic [7:0] nb, logic last,
                            logic [15:0] t, logic [31:0] a);
      int len, cap, e;
      logic [BKT_W-1:0] b;
      cache_answer_t ans;
      bit ev;
      if (cur_len < NAME_BYTES) cur_name[cur_len] = nb;
      if (cur_len <= NAME_BYTES) cur_len++;
      hash = (hash << HASH_SHIFT) + hash + nb;
      if (!last) return;
      len = cur_len;
      b = hash[BKT_W-1:0];
      cur_len = 0;
      hash = HASH_SEED;
      cap = (capacity == 0) ? 1 : int'(capacity);
      if (cap > ENTRIES) cap = ENTRIES;
      if (req == REQ_RSVD) return;
      ans.addr = '0;
      if (req == REQ_EVICT) begin
        ans.status = drop_oldest() ? ST_EVICTED : ST_NO_EVICT;
      end else if (req == REQ_INSERT && t != TYPE_A) begin
        ans.status = ST_SKIPPED;
      end else if (len > NAME_BYTES) begin
        ans.status = ST_TOO_LONG;
      end else if (req == REQ_QUERY) begin
        e = lookup(len, b, t);
        if (e >= 0) begin
          ans.addr = addrs[e];
          touch(e);
          ans.status = ST_HIT;
        end else begin
          ans.status = ST_MISS;
        end
      end else begin
        e = lookup(len, b, t);
        if (e >= 0) begin
          addrs[e] = a;
          touch(e);
          ans.status = ST_UPDATED;
        end else begin
          ev = 0;
          if (held >= cap) ev = drop_oldest();
          add(len, b, t, a);
          ans.status = ev ? ST_ADD_EVICT : ST_ADDED;
        end
      end
      ans.count = held[CNT_W-1:0];
      owed.push_back(ans);
    endfunction

    function void check_result(logic [3:0] st, logic [31:0] a, logic [CNT_W-1:0] c);
      cache_answer_t x;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d addr %h count %0d", st, a, c);
        return;
      end
      x = owed.pop_front();
      if (st !== x.status || a !== x.addr || c !== x.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp status %0d addr %h count %0d, got %0d %h %0d",
                   x.status, x.addr, x.count, st, a, c);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CAP_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         req_type_i;
  logic [7:0]         name_byte_i;
  logic               name_last_i;
  logic [15:0]        record_type_i;
  logic [31:0]        address_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [3:0]         status_o;
  logic [31:0]        address_out_o;
  logic [CNT_W-1:0]   entry_count_o;

  name_keyed_lru_cache i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .name_byte_i   (name_byte_i),
    .name_last_i   (name_last_i),
    .record_type_i (record_type_i),
    .address_in_i  (address_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .address_out_o (address_out_o),
    .entry_count_o (entry_count_o)
  );

  lru_scoreboard sb = new();
  bit  steady;        // set during the stretch with no idling on either side
  int  words_sent;
  int  cycles;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Inputs start known; reset is held low at the start and released once.
  initial begin
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = '0;
    in_valid_i = 0;
    req_type_i = '0;
    name_byte_i = '0;
    name_last_i = 0;
    record_type_i = '0;
    address_in_i = '0;
    out_stall_i = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  // Result side stalls about a quarter of the time, never in the steady stretch.
  always @(posedge clk_i)
    out_stall_i <= !steady && ($urandom_range(99) < 24);

  // Sample at the falling edge: everything is settled and the word is
  // certain to be taken at the next rising edge.
  always @(negedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, address_out_o, entry_count_o);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("name_keyed_lru_cache verification failed");
      $finish;
    end
  end

  // One request word; returns at the rising edge that took it.
  task automatic send_word(logic [1:0] req, logic [7:0] nb, logic last,
                           logic [15:0] t, logic [31:0] a);
    bit taken;
    if (!steady && $urandom_range(99) < 24) begin
      in_valid_i <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    req_type_i <= req;
    name_byte_i <= nb;
    name_last_i <= last;
    record_type_i <= t;
    address_in_i <= a;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_word(req, nb, last, t, a);
    words_sent++;
  endtask

  // Whole name; request fields carry noise until the last byte.
  task automatic send_request(logic [1:0] req, logic [7:0] nm[$],
                              logic [15:0] t, logic [31:0] a);
    for (int i = 0; i < nm.size(); i++) begin
      if (i == nm.size() - 1) send_word(req, nm[i], 1, t, a);
      else send_word(2'($urandom), nm[i], 0, 16'($urandom), $urandom);
    end
  endtask

  // Capacity writes only once the cache has gone quiet.
  task automatic set_capacity(logic [CAP_W-1:0] v);
    in_valid_i <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.capacity = v;
  endtask

  task automatic make_name(output logic [7:0] nm[$], input int len);
    nm = {};
    repeat (len) nm.push_back(8'($urandom));
  endtask

  initial begin
    logic [7:0] nm[$];
    logic [7:0] pool[16][$];
    logic [CAP_W-1:0] caps[7] = '{7'd1, 7'd0, 7'd3, 7'd127, 7'd8, 7'd64, 7'd2};
    int r, phase, per_phase, base;
    logic [1:0] req;
    logic [15:0] t;

    steady = 0;
    words_sent = 0;
    cycles = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // ---- directed part ----
    nm = {8'h61};
    send_request(REQ_QUERY, nm, TYPE_A, 32'h0);           // empty cache miss
    send_request(REQ_EVICT, nm, TYPE_A, 32'h0);           // nothing to evict
    send_request(REQ_INSERT, nm, 16'd28, 32'hFFFF_FFFF);  // non-A skipped
    nm = {8'h00, 8'hFF, 8'h00};                           // zero bytes are ordinary
    send_request(REQ_INSERT, nm, TYPE_A, 32'hFFFF_FFFF);
    send_request(REQ_QUERY, nm, TYPE_A, 32'h0);
    send_request(REQ_INSERT, nm, TYPE_A, 32'h0000_0000);  // refresh
    send_request(REQ_QUERY, nm, 16'hFFFF, 32'h0);         // wrong type misses
    send_request(REQ_QUERY, nm, TYPE_A, 32'h0);
    send_request(REQ_RSVD, nm, TYPE_A, 32'h0);            // reserved: no answer
    send_request(REQ_EVICT, nm, TYPE_A, 32'h0);
    // full length name, then one byte too long
    make_name(nm, NAME_BYTES);
    send_request(REQ_INSERT, nm, TYPE_A, 32'h0A0B_0C0D);
    send_request(REQ_QUERY, nm, TYPE_A, 32'h0);
    nm.push_back(8'h7F);
    send_request(REQ_QUERY, nm, TYPE_A, 32'h0);
    send_request(REQ_INSERT, nm, TYPE_A, 32'h1);
    nm = {8'h62};
    send_request(REQ_EVICT, nm, TYPE_A, 32'h0);

    // ---- random phases, one capacity setting each ----
    set_capacity(7'd64);
    base = words_sent;
    per_phase = (ITEM_TARGET - base) / $size(caps);
    for (phase = 0; phase < $size(caps); phase++) begin
      for (int p = 0; p < 16; p++) make_name(pool[p], $urandom_range(12, 1));
      while (words_sent < base + per_phase * (phase + 1)) begin
        steady = (phase == 3);
        r = $urandom_range(99);
        if (r < 15) make_name(nm, $urandom_range(6, 1));
        else nm = pool[$urandom_range(15)];
        r = $urandom_range(99);
        if (r < 45) req = REQ_QUERY;
        else if (r < 82) req = REQ_INSERT;
        else if (r < 96) req = REQ_EVICT;
        else req = REQ_RSVD;
        t = ($urandom_range(99) < 85) ? TYPE_A : 16'($urandom);
        send_request(req, nm, t, $urandom);
      end
      steady = 0;
      set_capacity(caps[phase]);
    end

    // ---- drain ----
    in_valid_i <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("name_keyed_lru_cache verification clean");
    end else begin
      $display("name_keyed_lru_cache verification failed");
    end
    $finish;
  end

endmodule
